FILE: src/tst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_pkg
// shared types and constants of the two-slot transposition table
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int DEF_ENTRIES   = 4096;
  localparam int DEF_MOVE_BITS = 16;

  localparam int KEY_W      = 64;
  localparam int SCORE_W    = 16;
  localparam int DEPTH_W    = 8;
  localparam int BOUND_W    = 2;
  localparam int PLY_W      = 8;
  localparam int MOVE_IO_W  = 16;

  localparam logic signed [SCORE_W-1:0] MATE_LIMIT = 16'sd19000;
  localparam logic signed [SCORE_W+1:0] SAT_MAX    = 18'sd32767;
  localparam logic signed [SCORE_W+1:0] SAT_MIN    = -18'sd32768;

  typedef enum logic [1:0] {
    REQ_PROBE = 2'd0,
    REQ_STORE = 2'd1,
    REQ_AGE   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_EVAL,
    ST_AGE,
    ST_AGE_TAIL
  } state_t;

endpackage

FILE: src/two_slot_transposition_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_slot_transposition_table
// hash table of search results, two slots per key, depth preferred
// ----------------------------------------------------------------------------
// Requests enter on the in_ channel (valid/stall); a transaction is taken at
// a clock edge with in_valid high and in_stall low. Only probes return a
// result on the out_ channel; store, age-all and clear-all return nothing.
// ENTRIES is a power of two. For a probe or store the home slot is the key
// modulo (ENTRIES-1), found by folding one log2(ENTRIES)-bit key chunk per
// cycle (12 bits at 4096 entries); then both slots are read together from
// the entry memory and the updated entry is written back in the write-back
// state. A halted store returns to idle with no hash and no write. Age-all
// and clear-all sweep the memory one entry a cycle. The block takes no new
// request until it is back in idle.
// After reset the block runs a clearing pass over all entries with in_stall
// high. A probe result waits in the output register while out_stall is high;
// a waiting result holds a following probe in its write-back state until taken.
// ----------------------------------------------------------------------------
module two_slot_transposition_table #(
  parameter int ENTRIES   = tst_pkg::DEF_ENTRIES,
  parameter int MOVE_BITS = tst_pkg::DEF_MOVE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic [tst_pkg::KEY_W-1:0]           in_pos_key,
  input  logic signed [tst_pkg::SCORE_W-1:0]  in_score,
  input  logic signed [tst_pkg::SCORE_W-1:0]  in_static_score,
  input  logic [tst_pkg::DEPTH_W-1:0]         in_search_depth,
  input  logic [tst_pkg::MOVE_IO_W-1:0]       in_best_move_word,
  input  logic [tst_pkg::BOUND_W-1:0]         in_bound_kind,
  input  logic [tst_pkg::PLY_W-1:0]           in_ply_count,
  input  logic                                in_halt_store,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic signed [tst_pkg::SCORE_W-1:0]  out_hit_score,
  output logic signed [tst_pkg::SCORE_W-1:0]  out_hit_static,
  output logic [tst_pkg::DEPTH_W-1:0]         out_hit_depth,
  output logic [tst_pkg::BOUND_W-1:0]         out_hit_bound,
  output logic [tst_pkg::MOVE_IO_W-1:0]       out_hit_move
);

  import tst_pkg::*;

  localparam int AW     = $clog2(ENTRIES);
  localparam int WORD_W = 2 + KEY_W + 2 * SCORE_W + DEPTH_W + BOUND_W + MOVE_BITS;
  localparam int REST_W = WORD_W - 2;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  state_t state_r, state_nxt;

  req_t                      req_r;
  logic [KEY_W-1:0]          key_r;
  logic signed [SCORE_W-1:0] score_r;
  logic signed [SCORE_W-1:0] static_r;
  logic [DEPTH_W-1:0]        depth_r;
  logic [MOVE_BITS-1:0]      move_r;
  logic [BOUND_W-1:0]        bound_r;
  logic [PLY_W-1:0]          ply_r;

  logic [AW-1:0] cnt_r;
  logic [AW-1:0] age_wa_r;
  logic          age_wv_r;

  logic                      out_valid_r;
  logic                      out_hit_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic signed [SCORE_W-1:0] out_static_r;
  logic [DEPTH_W-1:0]        out_depth_r;
  logic [BOUND_W-1:0]        out_bound_r;
  logic [MOVE_IO_W-1:0]      out_move_r;

  logic in_accept;
  logic mod_start, mod_done;
  logic [AW-1:0] home, next_slot;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr_a, mem_raddr_b;
  logic [WORD_W-1:0] rd_home, rd_next;

  logic                      ha_used, ha_aged;
  logic [KEY_W-1:0]          ha_key;
  logic signed [SCORE_W-1:0] ha_score, ha_static;
  logic [DEPTH_W-1:0]        ha_depth;
  logic [BOUND_W-1:0]        ha_bound;
  logic [MOVE_BITS-1:0]      ha_move;
  logic                      nb_used, nb_aged;
  logic [KEY_W-1:0]          nb_key;
  logic signed [SCORE_W-1:0] nb_score, nb_static;
  logic [DEPTH_W-1:0]        nb_depth;
  logic [BOUND_W-1:0]        nb_bound;
  logic [MOVE_BITS-1:0]      nb_move;

  logic                      hit_home, hit_next, hit_any;
  logic signed [SCORE_W-1:0] sel_score, sel_static, adj_score;
  logic [DEPTH_W-1:0]        sel_depth;
  logic [BOUND_W-1:0]        sel_bound;
  logic [MOVE_BITS-1:0]      sel_move;
  logic [WORD_W-1:0]         sel_word;
  logic signed [SCORE_W:0]   probe_sum;
  logic signed [SCORE_W+1:0] store_sum;
  logic signed [SCORE_W-1:0] store_score;
  logic                      wr_home, wr_next;
  logic [WORD_W-1:0]         store_word;
  logic                      out_load;
  logic                      eval_done;

  assign in_accept = in_valid && !in_stall;

  tst_mod #(
    .ENTRIES (ENTRIES)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .key   (in_pos_key),
    .done  (mod_done),
    .rem   (home)
  );

  assign next_slot = home + 1'b1;

  tst_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (rd_home),
    .rdata_b (rd_next)
  );

  assign {ha_used, ha_aged, ha_key, ha_score, ha_static, ha_depth, ha_bound, ha_move} = rd_home;
  assign {nb_used, nb_aged, nb_key, nb_score, nb_static, nb_depth, nb_bound, nb_move} = rd_next;

  // probe path
  assign hit_home = ha_used && (ha_key == key_r);
  assign hit_next = nb_used && (nb_key == key_r);
  assign hit_any  = hit_home || hit_next;

  assign sel_score  = hit_home ? ha_score  : nb_score;
  assign sel_static = hit_home ? ha_static : nb_static;
  assign sel_depth  = hit_home ? ha_depth  : nb_depth;
  assign sel_bound  = hit_home ? ha_bound  : nb_bound;
  assign sel_move   = hit_home ? ha_move   : nb_move;
  assign sel_word   = hit_home ? rd_home   : rd_next;

  always_comb begin
    probe_sum = {sel_score[SCORE_W-1], sel_score};
    if (sel_score > MATE_LIMIT) begin
      probe_sum = probe_sum - $signed({1'b0, ply_r});
    end else if (sel_score < -MATE_LIMIT) begin
      probe_sum = probe_sum + $signed({1'b0, ply_r});
    end
  end
  assign adj_score = probe_sum[SCORE_W-1:0];

  // store path
  always_comb begin
    store_sum = {{2{score_r[SCORE_W-1]}}, score_r};
    if (score_r > MATE_LIMIT) begin
      store_sum = store_sum + $signed({2'b00, ply_r});
    end else if (score_r < -MATE_LIMIT) begin
      store_sum = store_sum - $signed({2'b00, ply_r});
    end
    priority if (store_sum > SAT_MAX) begin
      store_score = SAT_MAX[SCORE_W-1:0];
    end else if (store_sum < SAT_MIN) begin
      store_score = SAT_MIN[SCORE_W-1:0];
    end else begin
      store_score = store_sum[SCORE_W-1:0];
    end
  end

  assign wr_home = !ha_used || ((ha_key == key_r) && (ha_depth <= depth_r)) || ha_aged;
  assign wr_next = !wr_home && (ha_key != key_r) && ((nb_depth <= depth_r) || nb_aged);
  assign store_word = {1'b1, 1'b0, key_r, store_score, static_r, depth_r, bound_r, move_r};

  assign eval_done = (req_r != REQ_PROBE) || !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          unique case (req_t'(in_req_type))
            REQ_PROBE: state_nxt = ST_HASH;
            REQ_STORE: state_nxt = in_halt_store ? ST_IDLE : ST_HASH;
            REQ_AGE:   state_nxt = ST_AGE;
            REQ_CLEAR: state_nxt = ST_CLEAR;
          endcase
        end
      end
      ST_HASH: begin
        if (mod_done) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (eval_done) state_nxt = ST_IDLE;
      end
      ST_AGE: begin
        if (cnt_r == LAST_ADDR) state_nxt = ST_AGE_TAIL;
      end
      ST_AGE_TAIL: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    mod_start   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = home;
    mem_wdata   = store_word;
    mem_raddr_a = home;
    mem_raddr_b = next_slot;
    out_load    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mod_start = in_accept && ((req_t'(in_req_type) == REQ_PROBE) ||
                                  ((req_t'(in_req_type) == REQ_STORE) && !in_halt_store));
      end
      ST_HASH: begin
      end
      ST_EVAL: begin
        if (req_r == REQ_PROBE) begin
          out_load  = eval_done;
          mem_we    = eval_done && hit_any;
          mem_waddr = hit_home ? home : next_slot;
          mem_wdata = {sel_word[WORD_W-1], 1'b0, sel_word[REST_W-1:0]};
        end else begin
          mem_we    = wr_home || wr_next;
          mem_waddr = wr_home ? home : next_slot;
          mem_wdata = store_word;
        end
      end
      ST_AGE: begin
        mem_raddr_a = cnt_r;
        mem_we      = age_wv_r;
        mem_waddr   = age_wa_r;
        mem_wdata   = {rd_home[WORD_W-1], 1'b1, rd_home[REST_W-1:0]};
      end
      ST_AGE_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = age_wa_r;
        mem_wdata = {rd_home[WORD_W-1], 1'b1, rd_home[REST_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      age_wv_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      age_wv_r <= (state_r == ST_AGE);
      if ((state_r == ST_CLEAR) || (state_r == ST_AGE)) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_AGE) begin
      age_wa_r <= cnt_r;
    end
    if (in_accept) begin
      req_r    <= req_t'(in_req_type);
      key_r    <= in_pos_key;
      score_r  <= in_score;
      static_r <= in_static_score;
      depth_r  <= in_search_depth;
      move_r   <= MOVE_BITS'(in_best_move_word);
      bound_r  <= in_bound_kind;
      ply_r    <= in_ply_count;
    end
    if (out_load) begin
      out_hit_r    <= hit_any;
      out_score_r  <= hit_any ? adj_score  : '0;
      out_static_r <= hit_any ? sel_static : '0;
      out_depth_r  <= hit_any ? sel_depth  : '0;
      out_bound_r  <= hit_any ? sel_bound  : '0;
      out_move_r   <= hit_any ? MOVE_IO_W'(sel_move) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_hit_score  = out_score_r;
  assign out_hit_static = out_static_r;
  assign out_hit_depth  = out_depth_r;
  assign out_hit_bound  = out_bound_r;
  assign out_hit_move   = out_move_r;

endmodule

FILE: src/tst_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_mod
// key modulo (ENTRIES-1) for a power-of-two ENTRIES, one address-wide chunk
// of the key folded per cycle with end-around carry
// ----------------------------------------------------------------------------
module tst_mod #(
  parameter int ENTRIES = tst_pkg::DEF_ENTRIES,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [tst_pkg::KEY_W-1:0] key,
  output logic                     done,
  output logic [AW-1:0]            rem
);

  import tst_pkg::*;

  localparam int STEPS  = (KEY_W + AW - 1) / AW;
  localparam int PAD_W  = STEPS * AW;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
  localparam logic [AW-1:0] ALL_ONES = '1;

  logic [PAD_W-1:0]  key_r;
  logic [AW-1:0]     acc_r, acc_nxt;
  logic [AW:0]       sum;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  // 2^AW is 1 modulo 2^AW-1, so the carry wraps to bit 0
  always_comb begin
    sum     = {1'b0, acc_r} + {1'b0, key_r[AW-1:0]};
    acc_nxt = sum[AW-1:0] + AW'(sum[AW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= PAD_W'(key);
      acc_r <= '0;
    end else if (busy_r) begin
      key_r <= key_r >> AW;
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign rem  = (acc_r == ALL_ONES) ? '0 : acc_r;

endmodule

FILE: src/tst_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_mem
// entry memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module tst_mem #(
  parameter int DEPTH = tst_pkg::DEF_ENTRIES,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-slot transposition table: a shadow table
// in the bench tracks every accepted request and predicts each probe result,
// directed cases cover field extremes, mate scores and slot replacement,
// then keyed random traffic runs under random idling and output hold-off
// ----------------------------------------------------------------------------
module tb_top;
  import tst_pkg::*;

  localparam int TT_ENTRIES     = DEF_ENTRIES;
  localparam int MATE_BOUND     = MATE_LIMIT;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int POOL_SIZE      = 32;

  typedef struct packed {
    req_t              req;
    logic [63:0]       key;
    logic signed [15:0] score;
    logic signed [15:0] stat_eval;
    logic [7:0]        depth;
    logic [15:0]       move;
    logic [1:0]        bound;
    logic [7:0]        ply;
    logic              halt;
  } tt_req_t;

  typedef struct packed {
    logic              hit;
    logic signed [15:0] score;
    logic signed [15:0] stat_eval;
    logic [7:0]        depth;
    logic [1:0]        bound;
    logic [15:0]       move;
  } tt_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_req_type;
  logic [KEY_W-1:0] in_pos_key;
  logic signed [SCORE_W-1:0] in_score;
  logic signed [SCORE_W-1:0] in_static_score;
  logic [DEPTH_W-1:0] in_search_depth;
  logic [MOVE_IO_W-1:0] in_best_move_word;
  logic [BOUND_W-1:0] in_bound_kind;
  logic [PLY_W-1:0] in_ply_count;
  logic in_halt_store;
  logic out_valid;
  logic out_stall;
  logic out_hit;
  logic signed [SCORE_W-1:0] out_hit_score;
  logic signed [SCORE_W-1:0] out_hit_static;
  logic [DEPTH_W-1:0] out_hit_depth;
  logic [BOUND_W-1:0] out_hit_bound;
  logic [MOVE_IO_W-1:0] out_hit_move;

  // shadow table
  logic [63:0]        tt_key   [TT_ENTRIES];
  logic signed [15:0] tt_score [TT_ENTRIES];
  logic signed [15:0] tt_stat  [TT_ENTRIES];
  logic [7:0]         tt_depth [TT_ENTRIES];
  logic [1:0]         tt_bound [TT_ENTRIES];
  logic [15:0]        tt_move  [TT_ENTRIES];
  logic               tt_aged  [TT_ENTRIES];
  logic               tt_used  [TT_ENTRIES];

  tt_result_t expected_probes[$];
  logic [63:0] key_pool [POOL_SIZE];
  int mismatch_count;
  bit calm_run;
  bit holdoff_req;

  two_slot_transposition_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_pos_key       (in_pos_key),
    .in_score         (in_score),
    .in_static_score  (in_static_score),
    .in_search_depth  (in_search_depth),
    .in_best_move_word(in_best_move_word),
    .in_bound_kind    (in_bound_kind),
    .in_ply_count     (in_ply_count),
    .in_halt_store    (in_halt_store),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_hit_score    (out_hit_score),
    .out_hit_static   (out_hit_static),
    .out_hit_depth    (out_hit_depth),
    .out_hit_bound    (out_hit_bound),
    .out_hit_move     (out_hit_move)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic tt_req_t make_req(req_t q, logic [63:0] key, int score = 0,
                                       int stat_eval = 0, int depth = 0, int move = 0,
                                       int bound = 0, int ply = 0, bit halt = 1'b0);
    tt_req_t r;
    r.req       = q;
    r.key       = key;
    r.score     = 16'(score);
    r.stat_eval = 16'(stat_eval);
    r.depth     = 8'(depth);
    r.move      = 16'(move);
    r.bound     = 2'(bound);
    r.ply       = 8'(ply);
    r.halt      = halt;
    return r;
  endfunction

  // shadow table update and probe result prediction for one transaction
  task automatic apply_to_table(input tt_req_t r);
    int unsigned home;
    int unsigned nxt;
    int unsigned slot;
    bit found;
    int s;
    tt_result_t res;
    home  = 32'(r.key % 64'(TT_ENTRIES - 1));
    nxt   = home + 1;
    slot  = 0;
    found = 1'b0;
    case (r.req)
      REQ_PROBE: begin
        res = '0;
        if (tt_used[home] && tt_key[home] == r.key) begin
          slot  = home;
          found = 1'b1;
        end else if (tt_used[nxt] && tt_key[nxt] == r.key) begin
          slot  = nxt;
          found = 1'b1;
        end
        if (found) begin
          tt_aged[slot] = 1'b0;
          s = tt_score[slot];
          if (s > MATE_BOUND) s = s - int'(r.ply);
          else if (s < -MATE_BOUND) s = s + int'(r.ply);
          res.hit       = 1'b1;
          res.score     = 16'(s);
          res.stat_eval = tt_stat[slot];
          res.depth     = tt_depth[slot];
          res.bound     = tt_bound[slot];
          res.move      = tt_move[slot];
        end
        expected_probes.push_back(res);
      end
      REQ_STORE: begin
        if (!r.halt) begin
          if (!tt_used[home] || (tt_key[home] == r.key && tt_depth[home] <= r.depth) ||
              tt_aged[home]) begin
            slot  = home;
            found = 1'b1;
          end else if (tt_key[home] != r.key && (tt_depth[nxt] <= r.depth || tt_aged[nxt])) begin
            slot  = nxt;
            found = 1'b1;
          end
          if (found) begin
            s = r.score;
            if (s > MATE_BOUND) s = s + int'(r.ply);
            else if (s < -MATE_BOUND) s = s - int'(r.ply);
            if (s > int'(SAT_MAX)) s = SAT_MAX;
            if (s < int'(SAT_MIN)) s = SAT_MIN;
            tt_key[slot]   = r.key;
            tt_score[slot] = 16'(s);
            tt_stat[slot]  = r.stat_eval;
            tt_depth[slot] = r.depth;
            tt_move[slot]  = r.move;
            tt_bound[slot] = r.bound;
            tt_aged[slot]  = 1'b0;
            tt_used[slot]  = 1'b1;
          end
        end
      end
      REQ_AGE: begin
        for (int i = 0; i < TT_ENTRIES; i++) tt_aged[i] = 1'b1;
      end
      default: begin
        for (int i = 0; i < TT_ENTRIES; i++) begin
          tt_key[i]   = '0;
          tt_score[i] = '0;
          tt_depth[i] = '0;
          tt_move[i]  = '0;
          tt_aged[i]  = 1'b0;
          tt_used[i]  = 1'b0;
        end
      end
    endcase
  endtask

  // entered and left at a falling edge
  task automatic send_request(input tt_req_t r);
    int gap;
    if (!calm_run && $urandom_range(0, 99) < 21) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= r.req;
    in_pos_key        <= r.key;
    in_score          <= r.score;
    in_static_score   <= r.stat_eval;
    in_search_depth   <= r.depth;
    in_best_move_word <= r.move;
    in_bound_kind     <= r.bound;
    in_ply_count      <= r.ply;
    in_halt_store     <= r.halt;
    do @(posedge clk); while (in_stall);
    apply_to_table(r);
    @(negedge clk);
  endtask

  function automatic tt_req_t rand_request();
    tt_req_t r;
    int sc;
    r.req = ($urandom_range(0, 99) < 45) ? REQ_PROBE : REQ_STORE;
    if ($urandom_range(0, 99) < 80) r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else r.key = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: sc = MATE_BOUND;
      1: sc = MATE_BOUND + 1;
      2: sc = -MATE_BOUND;
      3: sc = -MATE_BOUND - 1;
      4: sc = $urandom_range(MATE_BOUND + 1, 32767);
      5: sc = -int'($urandom_range(MATE_BOUND + 1, 32768));
      default: sc = $urandom;
    endcase
    r.score     = 16'(sc);
    r.stat_eval = 16'($urandom);
    r.depth     = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    r.move      = 16'($urandom);
    r.bound     = 2'($urandom);
    r.ply       = 8'($urandom);
    r.halt      = ($urandom_range(0, 99) < 10);
    return r;
  endfunction

  always @(posedge clk) begin
    tt_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_probes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected probe result: hit %0b score %0d", out_hit, out_hit_score);
      end else begin
        want = expected_probes.pop_front();
        if (out_hit !== want.hit || out_hit_score !== want.score ||
            out_hit_static !== want.stat_eval || out_hit_depth !== want.depth ||
            out_hit_bound !== want.bound || out_hit_move !== want.move) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("probe mismatch: expected hit %0b score %0d static %0d depth %0d bound %0d move %h",
                     want.hit, $signed(want.score), $signed(want.stat_eval), want.depth,
                     want.bound, want.move);
            $display("                actual   hit %0b score %0d static %0d depth %0d bound %0d move %h",
                     out_hit, out_hit_score, out_hit_static, out_hit_depth, out_hit_bound,
                     out_hit_move);
          end
        end
      end
    end
  end

  // result side: random stall, calm stretch, and one long hold-off
  initial begin
    int held;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        out_stall <= 1'b1;
        held = 1;
        while (held < HOLDOFF_CYCLES) begin
          @(negedge clk);
          held++;
        end
        holdoff_req = 1'b0;
      end else begin
        out_stall <= !calm_run && ($urandom_range(0, 99) < 21);
      end
    end
  end

  task automatic test_empty_probes();
    send_request(make_req(REQ_PROBE, 64'd0));
    send_request(make_req(REQ_PROBE, '1, .ply(255), .halt(1'b1)));
  endtask

  task automatic test_store_extremes();
    send_request(make_req(REQ_STORE, 64'h0123_4567_89AB_CDEF, 12345, -32768, 255, 16'hFFFF,
                          3, 255));
    send_request(make_req(REQ_PROBE, 64'h0123_4567_89AB_CDEF));
    send_request(make_req(REQ_STORE, '1, -1, 32767, 0, 0, 0, 0));
    send_request(make_req(REQ_PROBE, '1, .ply(7)));
  endtask

  task automatic test_mate_scores();
    send_request(make_req(REQ_STORE, 64'd5000, 32767, 1, 1, 16'h1234, 1, 200));
    send_request(make_req(REQ_PROBE, 64'd5000, .ply(100)));
    send_request(make_req(REQ_STORE, 64'd7000, -32768, 2, 2, 16'h4321, 2, 1));
    send_request(make_req(REQ_PROBE, 64'd7000, .ply(255)));
    send_request(make_req(REQ_STORE, 64'd9000, MATE_BOUND, 3, 3, 16'h0F0F, 0, 50));
    send_request(make_req(REQ_PROBE, 64'd9000, .ply(50)));
  endtask

  task automatic test_halted_store();
    send_request(make_req(REQ_STORE, 64'd11000, 77, 88, 4, 16'hAAAA, 1, 0, 1'b1));
    send_request(make_req(REQ_PROBE, 64'd11000));
  endtask

  // three keys sharing one home slot
  task automatic test_slot_replacement();
    send_request(make_req(REQ_STORE, 64'd100, 10, 10, 10, 16'h0010, 0, 0));
    send_request(make_req(REQ_STORE, 64'd4195, 20, 20, 5, 16'h0020, 1, 0));
    send_request(make_req(REQ_STORE, 64'd8290, 30, 30, 3, 16'h0030, 2, 0));
    send_request(make_req(REQ_PROBE, 64'd8290));
    send_request(make_req(REQ_AGE, 64'd0));
    send_request(make_req(REQ_STORE, 64'd8290, 30, 30, 3, 16'h0030, 2, 0));
    send_request(make_req(REQ_PROBE, 64'd100));
  endtask

  task automatic test_last_slot_and_clear();
    send_request(make_req(REQ_STORE, 64'd4094, 40, 40, 9, 16'h0040, 3, 0));
    send_request(make_req(REQ_STORE, 64'd8189, 50, 50, 1, 16'h0050, 0, 0));
    send_request(make_req(REQ_PROBE, 64'd8189));
    send_request(make_req(REQ_CLEAR, 64'd0));
    send_request(make_req(REQ_PROBE, 64'd0));
  endtask

  task automatic test_random_traffic(input int count);
    int unsigned homes [8];
    logic [63:0] mult;
    homes[0] = TT_ENTRIES - 2;
    homes[1] = TT_ENTRIES - 3;
    for (int h = 2; h < 8; h += 2) begin
      homes[h]     = $urandom_range(0, TT_ENTRIES - 3);
      homes[h + 1] = homes[h] + 1;
    end
    for (int j = 0; j < POOL_SIZE; j++) begin
      mult = (j < 8) ? 64'(j) : ({$urandom, $urandom} >> 12);
      key_pool[j] = 64'(homes[j % 8]) + 64'(TT_ENTRIES - 1) * mult;
    end
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 249) send_request(make_req(REQ_CLEAR, {$urandom, $urandom}));
      else if (i % 75 == 37) send_request(make_req(REQ_AGE, {$urandom, $urandom}));
      else send_request(rand_request());
    end
  endtask

  task automatic test_calm_stream(input int count);
    calm_run = 1'b1;
    for (int i = 0; i < count; i++) send_request(rand_request());
    calm_run = 1'b0;
  endtask

  task automatic test_output_holdoff(input int count);
    tt_req_t r;
    holdoff_req = 1'b1;
    for (int i = 0; i < count; i++) begin
      r = rand_request();
      if (i % 4 != 3) r.req = REQ_PROBE;
      send_request(r);
    end
  endtask

  initial begin
    int drain;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_req_type       = REQ_PROBE;
    in_pos_key        = '0;
    in_score          = '0;
    in_static_score   = '0;
    in_search_depth   = '0;
    in_best_move_word = '0;
    in_bound_kind     = '0;
    in_ply_count      = '0;
    in_halt_store     = 1'b0;
    mismatch_count    = 0;
    calm_run          = 1'b0;
    holdoff_req       = 1'b0;
    for (int i = 0; i < TT_ENTRIES; i++) begin
      tt_key[i]   = '0;
      tt_score[i] = '0;
      tt_stat[i]  = '0;
      tt_depth[i] = '0;
      tt_bound[i] = '0;
      tt_move[i]  = '0;
      tt_aged[i]  = 1'b0;
      tt_used[i]  = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_probes();
    test_store_extremes();
    test_mate_scores();
    test_halted_store();
    test_slot_replacement();
    test_last_slot_and_clear();
    test_random_traffic(1500);
    test_calm_stream(200);
    test_output_holdoff(50);

    in_valid <= 1'b0;
    drain = 0;
    while (expected_probes.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    if (expected_probes.size() != 0) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      repeat (TT_ENTRIES + 100) @(posedge clk);
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
    end
  end

endmodule

FILE: files.f
src/tst_pkg.sv
src/tst_mod.sv
src/tst_mem.sv
src/two_slot_transposition_table.sv
bench/tb_top.sv
